[rtl/oekf_pkg.sv]
// Package for the odometry EKF Jacobian evaluator: payload types, codes,
// constants and the micro-program table of the back end.
// Depends on nothing; every other file of the block uses it.
package oekf_pkg;

  // Width of an emitted element value, signed Q16.16.
  localparam int unsigned ValueW = 32;

  // Saturation bound of every intermediate, 2^62 - 1.
  localparam logic signed [63:0] Wmax = 64'sh3FFF_FFFF_FFFF_FFFF;

  // Angle constants in Q2.13 radians.
  localparam logic signed [16:0] PiQ13     = 17'sd25736;
  localparam logic signed [16:0] HalfPiQ13 = 17'sd12868;

  // CORDIC start value with the gain folded in, Q2.30.
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam int unsigned CordicSteps = 17;

  // Operation codes of a request.
  typedef enum logic [1:0] {
    OP_STATE = 2'd0,
    OP_INPUT = 2'd1,
    OP_MEAS  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_TICKS  = 2'd0,
    CFG_RADIUS = 2'd1,
    CFG_BASE   = 2'd2,
    CFG_UNUSED = 2'd3
  } cfg_idx_e;

  // Input transaction.
  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] steer_angle;
    logic signed [15:0] heading_now;
    logic signed [15:0] heading_before;
    logic signed [31:0] travel;
    logic [31:0]        time_now;
    logic [31:0]        time_before;
  } in_item_t;

  // Output transaction, one matrix element.
  typedef struct packed {
    logic [1:0]               row;
    logic [1:0]               col;
    logic signed [ValueW-1:0] value;
    logic                     saturated;
    logic                     last;
  } out_item_t;

  // Configuration register set.
  typedef struct packed {
    logic [15:0] ticks;
    logic [31:0] radius;
    logic [31:0] base;
  } cfg_t;

  // Micro-program chosen by the front end for one request.
  typedef enum logic [2:0] {
    PRG_A_TURN     = 3'd0,
    PRG_A_STRAIGHT = 3'd1,
    PRG_B_TURN     = 3'd2,
    PRG_B_STRAIGHT = 3'd3,
    PRG_H          = 3'd4
  } prog_e;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    prog_e              prog;
    logic signed [15:0] steer;
    logic signed [15:0] hnow;
    logic signed [15:0] hbef;
    logic signed [31:0] travel;
    logic [31:0]        tnow;
    logic [31:0]        tbef;
  } job_t;

  // Micro-operation kinds.
  typedef enum logic [2:0] {
    U_CORDIC = 3'd0,
    U_MUL    = 3'd1,
    U_DIV    = 3'd2,
    U_SUB    = 3'd3,
    U_EMIT   = 3'd4
  } uop_e;

  // Operand sources: scratch entries below 16, constants and fields from 16 up.
  typedef enum logic [4:0] {
    R_SSA       = 5'd0,
    R_CSA       = 5'd1,
    R_SCH       = 5'd2,
    R_CCH       = 5'd3,
    R_SPH       = 5'd4,
    R_CPH       = 5'd5,
    R_DPT       = 5'd6,
    R_Q         = 5'd7,
    R_T         = 5'd8,
    R_E0        = 5'd9,
    R_E1        = 5'd10,
    R_E2        = 5'd11,
    R_E3        = 5'd12,
    R_E4        = 5'd13,
    R_E5        = 5'd14,
    K_ZERO      = 5'd16,
    K_ONE       = 5'd17,
    K_ONE_Q16   = 5'd18,
    K_TWO_PI    = 5'd19,
    K_RADIUS    = 5'd20,
    K_TICKS     = 5'd21,
    K_BASE      = 5'd22,
    K_TRAVEL    = 5'd23,
    K_TNOW      = 5'd24,
    K_TBEF      = 5'd25,
    K_ONE_SHL32 = 5'd26,
    K_STEER     = 5'd27,
    K_HNOW      = 5'd28,
    K_HBEF      = 5'd29
  } src_e;

  // Right shift applied after a product.
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_14 = 2'd1,
    SH_16 = 2'd2,
    SH_30 = 2'd3
  } shift_e;

  typedef struct packed {
    uop_e       kind;
    src_e       a;
    src_e       b;
    src_e       dst;
    shift_e     sh;
    logic [1:0] row;
    logic [1:0] col;
    logic       last;
  } uop_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_ISSUE = 3'd1,
    BK_OPER  = 3'd2,
    BK_WAIT  = 3'd3,
    BK_COS   = 3'd4
  } back_state_e;

  // Arctangent table of the CORDIC, Q16 radians.
  function automatic logic [15:0] cordic_atan(input logic [4:0] idx);
    logic [15:0] v;
    begin
      unique case (idx)
        5'd0:    v = 16'd51472;
        5'd1:    v = 16'd30386;
        5'd2:    v = 16'd16055;
        5'd3:    v = 16'd8150;
        5'd4:    v = 16'd4091;
        5'd5:    v = 16'd2047;
        5'd6:    v = 16'd1024;
        5'd7:    v = 16'd512;
        5'd8:    v = 16'd256;
        5'd9:    v = 16'd128;
        5'd10:   v = 16'd64;
        5'd11:   v = 16'd32;
        5'd12:   v = 16'd16;
        5'd13:   v = 16'd8;
        5'd14:   v = 16'd4;
        5'd15:   v = 16'd2;
        5'd16:   v = 16'd1;
        default: v = 16'd0;
      endcase
      return v;
    end
  endfunction

  function automatic uop_t uop_mk(input uop_e k, input src_e a, input src_e b,
                                  input src_e d, input shift_e s,
                                  input logic [1:0] r, input logic [1:0] c,
                                  input logic l);
    uop_t u;
    begin
      u.kind = k;
      u.a    = a;
      u.b    = b;
      u.dst  = d;
      u.sh   = s;
      u.row  = r;
      u.col  = c;
      u.last = l;
      return u;
    end
  endfunction

  function automatic uop_t u_mul(input src_e a, input src_e b, input shift_e s,
                                 input src_e d);
    return uop_mk(U_MUL, a, b, d, s, 2'd0, 2'd0, 1'b0);
  endfunction

  function automatic uop_t u_div(input src_e a, input src_e b, input src_e d);
    return uop_mk(U_DIV, a, b, d, SH_0, 2'd0, 2'd0, 1'b0);
  endfunction

  function automatic uop_t u_sub(input src_e a, input src_e b, input src_e d);
    return uop_mk(U_SUB, a, b, d, SH_0, 2'd0, 2'd0, 1'b0);
  endfunction

  // Sine goes to d, cosine to the entry after it.
  function automatic uop_t u_cor(input src_e a, input src_e d);
    return uop_mk(U_CORDIC, a, K_ZERO, d, SH_0, 2'd0, 2'd0, 1'b0);
  endfunction

  function automatic uop_t u_emit(input src_e a, input logic [1:0] r,
                                  input logic [1:0] c, input logic l);
    return uop_mk(U_EMIT, a, K_ZERO, K_ZERO, SH_0, r, c, l);
  endfunction

  // Emission of the 3x3 state Jacobian, element k in row-major order.
  function automatic uop_t a_emit(input logic [3:0] k);
    uop_t u;
    begin
      unique case (k)
        4'd0:    u = u_emit(K_ONE_Q16, 2'd0, 2'd0, 1'b0);
        4'd1:    u = u_emit(K_ZERO,    2'd0, 2'd1, 1'b0);
        4'd2:    u = u_emit(R_E0,      2'd0, 2'd2, 1'b0);
        4'd3:    u = u_emit(K_ZERO,    2'd1, 2'd0, 1'b0);
        4'd4:    u = u_emit(K_ONE_Q16, 2'd1, 2'd1, 1'b0);
        4'd5:    u = u_emit(R_E1,      2'd1, 2'd2, 1'b0);
        4'd6:    u = u_emit(K_ZERO,    2'd2, 2'd0, 1'b0);
        4'd7:    u = u_emit(K_ZERO,    2'd2, 2'd1, 1'b0);
        default: u = u_emit(K_ONE_Q16, 2'd2, 2'd2, 1'b1);
      endcase
      return u;
    end
  endfunction

  // Micro-program table: one operation per program step.
  function automatic uop_t prog_uop(input prog_e p, input logic [4:0] pc);
    uop_t u;
    begin
      u = u_emit(K_ZERO, 2'd0, 2'd0, 1'b1);
      unique case (p)
        PRG_A_TURN: begin
          unique case (pc)
            5'd0:  u = u_cor(K_STEER, R_SSA);
            5'd1:  u = u_cor(K_HNOW, R_SCH);
            5'd2:  u = u_cor(K_HBEF, R_SPH);
            5'd3:  u = u_mul(K_BASE, R_CSA, SH_0, R_T);
            5'd4:  u = u_div(R_T, R_SSA, R_Q);
            5'd5:  u = u_sub(R_CCH, R_CPH, R_T);
            5'd6:  u = u_mul(R_Q, R_T, SH_30, R_E0);
            5'd7:  u = u_sub(R_SCH, R_SPH, R_T);
            5'd8:  u = u_mul(R_Q, R_T, SH_30, R_E1);
            default: u = a_emit(4'(pc - 5'd9));
          endcase
        end
        PRG_A_STRAIGHT: begin
          unique case (pc)
            5'd0:  u = u_cor(K_STEER, R_SSA);
            5'd1:  u = u_cor(K_HNOW, R_SCH);
            5'd2:  u = u_cor(K_HBEF, R_SPH);
            5'd3:  u = u_mul(K_TRAVEL, R_SPH, SH_30, R_T);
            5'd4:  u = u_sub(K_ZERO, R_T, R_E0);
            5'd5:  u = u_mul(K_TRAVEL, R_CPH, SH_30, R_E1);
            default: u = a_emit(4'(pc - 5'd6));
          endcase
        end
        PRG_B_TURN: begin
          unique case (pc)
            5'd0:  u = u_cor(K_STEER, R_SSA);
            5'd1:  u = u_cor(K_HNOW, R_SCH);
            5'd2:  u = u_cor(K_HBEF, R_SPH);
            5'd3:  u = u_mul(K_TWO_PI, K_RADIUS, SH_0, R_T);
            5'd4:  u = u_div(R_T, K_TICKS, R_T);
            5'd5:  u = u_mul(R_T, K_ONE, SH_16, R_DPT);
            5'd6:  u = u_mul(R_CSA, R_DPT, SH_30, R_T);
            5'd7:  u = u_mul(R_T, R_CCH, SH_30, R_E0);
            5'd8:  u = u_mul(R_CSA, R_DPT, SH_30, R_T);
            5'd9:  u = u_mul(R_T, R_SCH, SH_30, R_E2);
            5'd10: u = u_mul(R_SSA, R_DPT, SH_0, R_T);
            5'd11: u = u_div(R_T, K_BASE, R_T);
            5'd12: u = u_mul(R_T, K_ONE, SH_14, R_E4);
            5'd13: u = u_mul(R_CSA, R_CSA, SH_30, R_T);
            5'd14: u = u_mul(R_T, K_TRAVEL, SH_0, R_T);
            5'd15: u = u_div(R_T, R_SSA, R_Q);
            5'd16: u = u_mul(R_Q, R_CCH, SH_30, R_E1);
            5'd17: u = u_mul(R_Q, R_SCH, SH_30, R_E3);
            5'd18: u = u_mul(R_CSA, K_TRAVEL, SH_0, R_T);
            5'd19: u = u_div(R_T, K_BASE, R_T);
            5'd20: u = u_mul(R_T, K_ONE, SH_14, R_E5);
            5'd21: u = u_emit(R_E0, 2'd0, 2'd0, 1'b0);
            5'd22: u = u_emit(R_E1, 2'd0, 2'd1, 1'b0);
            5'd23: u = u_emit(R_E2, 2'd1, 2'd0, 1'b0);
            5'd24: u = u_emit(R_E3, 2'd1, 2'd1, 1'b0);
            5'd25: u = u_emit(R_E4, 2'd2, 2'd0, 1'b0);
            default: u = u_emit(R_E5, 2'd2, 2'd1, 1'b1);
          endcase
        end
        PRG_B_STRAIGHT: begin
          unique case (pc)
            5'd0:  u = u_cor(K_STEER, R_SSA);
            5'd1:  u = u_cor(K_HNOW, R_SCH);
            5'd2:  u = u_cor(K_HBEF, R_SPH);
            5'd3:  u = u_mul(K_TWO_PI, K_RADIUS, SH_0, R_T);
            5'd4:  u = u_div(R_T, K_TICKS, R_T);
            5'd5:  u = u_mul(R_T, K_ONE, SH_16, R_DPT);
            5'd6:  u = u_mul(R_DPT, R_CPH, SH_30, R_E0);
            5'd7:  u = u_mul(R_DPT, R_SPH, SH_30, R_E2);
            5'd8:  u = u_mul(R_CSA, K_TRAVEL, SH_0, R_T);
            5'd9:  u = u_div(R_T, K_BASE, R_T);
            5'd10: u = u_mul(R_T, K_ONE, SH_14, R_E5);
            5'd11: u = u_emit(R_E0, 2'd0, 2'd0, 1'b0);
            5'd12: u = u_emit(K_ZERO, 2'd0, 2'd1, 1'b0);
            5'd13: u = u_emit(R_E2, 2'd1, 2'd0, 1'b0);
            5'd14: u = u_emit(K_ZERO, 2'd1, 2'd1, 1'b0);
            5'd15: u = u_emit(K_ZERO, 2'd2, 2'd0, 1'b0);
            default: u = u_emit(R_E5, 2'd2, 2'd1, 1'b1);
          endcase
        end
        default: begin
          unique case (pc)
            5'd0:  u = u_sub(K_TNOW, K_TBEF, R_T);
            5'd1:  u = u_div(K_ONE_SHL32, R_T, R_E0);
            5'd2:  u = u_emit(K_ZERO, 2'd0, 2'd0, 1'b0);
            5'd3:  u = u_emit(K_ZERO, 2'd0, 2'd1, 1'b0);
            default: u = u_emit(R_E0, 2'd0, 2'd2, 1'b1);
          endcase
        end
      endcase
      return u;
    end
  endfunction

endpackage

[rtl/oekf_front.sv]
// Front end of the Jacobian evaluator: accepts requests, classifies them
// into micro-programs and holds them in a two-entry queue.
// Depends on oekf_pkg.
module oekf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  oekf_pkg::in_item_t in_item_i,
  output logic              job_valid_o,
  output oekf_pkg::job_t    job_o,
  input  logic              job_pop_i
);

  oekf_pkg::job_t q_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       full;
  logic       accept;
  logic       push;
  oekf_pkg::job_t job_new;

  assign full       = (cnt_q == 2'd2);
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Unused operation codes are accepted and dropped here.
  assign push = accept && (in_item_i.operation != oekf_pkg::OP_NONE);

  // Classify the request by matrix and by whether the wheel is steered.
  always_comb begin
    job_new.steer  = in_item_i.steer_angle;
    job_new.hnow   = in_item_i.heading_now;
    job_new.hbef   = in_item_i.heading_before;
    job_new.travel = in_item_i.travel;
    job_new.tnow   = in_item_i.time_now;
    job_new.tbef   = in_item_i.time_before;
    priority if (in_item_i.operation == oekf_pkg::OP_STATE) begin
      job_new.prog = (in_item_i.steer_angle != 16'sd0) ? oekf_pkg::PRG_A_TURN
                                                       : oekf_pkg::PRG_A_STRAIGHT;
    end else if (in_item_i.operation == oekf_pkg::OP_INPUT) begin
      job_new.prog = (in_item_i.steer_angle != 16'sd0) ? oekf_pkg::PRG_B_TURN
                                                       : oekf_pkg::PRG_B_STRAIGHT;
    end else begin
      job_new.prog = oekf_pkg::PRG_H;
    end
  end

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = job_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, job_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= job_new;
    end
  end

  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_q[rd_ptr_q];

endmodule

[rtl/oekf_mul.sv]
// Saturating 64 x 64 magnitude multiplier with a right shift, built from
// four 32 x 32 partial products taken one per cycle.
// Depends on oekf_pkg.
module oekf_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  input  oekf_pkg::shift_e   sh_i,
  output logic               done_o,
  output logic signed [63:0] res_o,
  output logic               ovf_o
);

  logic [63:0]  ua_q, ub_q;
  logic         neg_q;
  oekf_pkg::shift_e sh_q;
  logic [127:0] acc_q;
  logic [63:0]  pp_q;
  logic [1:0]   pos_q;
  logic [2:0]   cnt_q;
  logic         busy_q;
  logic         done_q;
  logic signed [63:0] res_q;
  logic         ovf_q;

  logic [31:0]  pa, pb;
  logic [127:0] pp_ext;
  logic [4:0]   shamt;
  logic [127:0] shifted;
  logic         ovf;
  logic [63:0]  mag_res;

  // Partial product operands and the shifted, clipped magnitude.
  always_comb begin
    pa     = cnt_q[0] ? ua_q[63:32] : ua_q[31:0];
    pb     = cnt_q[1] ? ub_q[63:32] : ub_q[31:0];
    pp_ext = {64'd0, pp_q} << {pos_q, 5'd0};
    unique case (sh_q)
      oekf_pkg::SH_0:  shamt = 5'd0;
      oekf_pkg::SH_14: shamt = 5'd14;
      oekf_pkg::SH_16: shamt = 5'd16;
      default:         shamt = 5'd30;
    endcase
    shifted = acc_q >> shamt;
    ovf     = |shifted[127:62];
    mag_res = ovf ? 64'(oekf_pkg::Wmax) : shifted[63:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
      ua_q   <= '0;
      ub_q   <= '0;
      neg_q  <= 1'b0;
      sh_q   <= oekf_pkg::SH_0;
      acc_q  <= '0;
      pp_q   <= '0;
      pos_q  <= 2'd0;
      res_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        ua_q   <= a_i[63] ? 64'(-a_i) : 64'(a_i);
        ub_q   <= b_i[63] ? 64'(-b_i) : 64'(b_i);
        neg_q  <= a_i[63] ^ b_i[63];
        sh_q   <= sh_i;
        acc_q  <= '0;
        cnt_q  <= 3'd0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // Multiply at counts 0 to 3, accumulate in the cycle after.
        if (cnt_q < 3'd4) begin
          pp_q  <= pa * pb;
          pos_q <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
        end
        if (cnt_q != 3'd0 && cnt_q < 3'd5) begin
          acc_q <= acc_q + pp_ext;
        end
        if (cnt_q == 3'd5) begin
          res_q  <= neg_q ? -$signed(mag_res) : $signed(mag_res);
          ovf_q  <= ovf;
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign ovf_o  = ovf_q;

endmodule

[rtl/oekf_div.sv]
// Signed 64-bit divider truncating toward zero, one quotient bit per cycle,
// with saturation on a zero divisor.
// Depends on oekf_pkg.
module oekf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] n_i,
  input  logic signed [63:0] d_i,
  output logic               done_o,
  output logic signed [63:0] res_o,
  output logic               ovf_o
);

  logic [63:0] un_q;
  logic [63:0] ud_q;
  logic [64:0] rem_q;
  logic [5:0]  cnt_q;
  logic        neg_q;
  logic        busy_q;
  logic        done_q;
  logic signed [63:0] res_q;
  logic        ovf_q;

  logic [64:0] rem_sh;
  logic [64:0] diff;
  logic        ge;
  logic [63:0] quo;

  // One restoring step.
  always_comb begin
    rem_sh = {rem_q[63:0], un_q[63]};
    diff   = rem_sh - {1'b0, ud_q};
    ge     = (rem_sh >= {1'b0, ud_q});
    quo    = {un_q[62:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
      un_q   <= '0;
      ud_q   <= '0;
      rem_q  <= '0;
      neg_q  <= 1'b0;
      res_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (d_i == 64'sd0) begin
          // Zero divisor: saturate toward the numerator's sign.
          res_q  <= n_i[63] ? -oekf_pkg::Wmax : oekf_pkg::Wmax;
          ovf_q  <= 1'b1;
          done_q <= 1'b1;
        end else begin
          un_q   <= n_i[63] ? 64'(-n_i) : 64'(n_i);
          ud_q   <= d_i[63] ? 64'(-d_i) : 64'(d_i);
          neg_q  <= n_i[63] ^ d_i[63];
          rem_q  <= '0;
          cnt_q  <= 6'd0;
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q <= ge ? diff : rem_sh;
        un_q  <= quo;
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          res_q  <= neg_q ? -$signed(quo) : $signed(quo);
          ovf_q  <= 1'b0;
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign ovf_o  = ovf_q;

endmodule

[rtl/oekf_cordic.sv]
// Rotation-mode CORDIC giving sine and cosine in Q2.30 of a Q2.13 angle,
// one micro-rotation per cycle.
// Depends on oekf_pkg.
module oekf_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] angle_i,
  output logic               done_o,
  output logic signed [63:0] sin_o,
  output logic signed [63:0] cos_o
);

  logic signed [33:0] x_q, y_q;
  logic signed [19:0] z_q;
  logic [4:0]         i_q;
  logic               neg_q;
  logic               busy_q;
  logic               done_q;
  logic signed [63:0] sin_q, cos_q;

  logic signed [16:0] ang;
  logic               ang_neg;
  logic signed [33:0] xs, ys, nx, ny;
  logic signed [19:0] at, nz;
  logic signed [63:0] xe, ye;

  // Fold the angle into the half circle around zero.
  always_comb begin
    ang     = {angle_i[15], angle_i};
    ang_neg = 1'b0;
    priority if (ang > oekf_pkg::HalfPiQ13) begin
      ang     = ang - oekf_pkg::PiQ13;
      ang_neg = 1'b1;
    end else if (ang < -oekf_pkg::HalfPiQ13) begin
      ang     = ang + oekf_pkg::PiQ13;
      ang_neg = 1'b1;
    end else begin
      ang_neg = 1'b0;
    end
  end

  // One micro-rotation.
  always_comb begin
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    at = $signed({4'd0, oekf_pkg::cordic_atan(i_q)});
    if (!z_q[19]) begin
      nx = x_q - ys;
      ny = y_q + xs;
      nz = z_q - at;
    end else begin
      nx = x_q + ys;
      ny = y_q - xs;
      nz = z_q + at;
    end
    xe = {{30{nx[33]}}, nx};
    ye = {{30{ny[33]}}, ny};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= 5'd0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      neg_q  <= 1'b0;
      sin_q  <= '0;
      cos_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        x_q    <= oekf_pkg::CordicGain;
        y_q    <= '0;
        z_q    <= {ang, 3'b000};
        neg_q  <= ang_neg;
        i_q    <= 5'd0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        x_q <= nx;
        y_q <= ny;
        z_q <= nz;
        i_q <= i_q + 5'd1;
        if (i_q == 5'(oekf_pkg::CordicSteps - 1)) begin
          sin_q  <= neg_q ? -ye : ye;
          cos_q  <= neg_q ? -xe : xe;
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

[rtl/oekf_back.sv]
// Back end of the Jacobian evaluator: a micro-programmed sequencer over a
// scratch memory, a shared multiplier, divider and CORDIC, and an output
// register. Depends on oekf_pkg, oekf_mul, oekf_div and oekf_cordic.
module oekf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  oekf_pkg::cfg_t      cfg_i,
  input  logic                job_valid_i,
  input  oekf_pkg::job_t      job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output oekf_pkg::out_item_t out_item_o
);

  localparam logic signed [63:0] Lim = 64'sd2 ** (oekf_pkg::ValueW - 1) - 64'sd1;

  oekf_pkg::back_state_e state_q, state_d;
  logic [4:0]          pc_q, pc_d;
  oekf_pkg::job_t      job_q;
  logic                oflag_q, oflag_d;
  oekf_pkg::out_item_t out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic [64:0]         rda_q, rdb_q;
  logic [64:0]         mem [16];

  oekf_pkg::uop_t      uop;
  logic signed [63:0]  va, vb, vdiff;
  logic                fa, fb;
  logic                we;
  logic [3:0]          waddr;
  logic [64:0]         wdata;
  logic                mul_start, div_start, cor_start;
  logic                mul_done, div_done, cor_done;
  logic signed [63:0]  mul_res, div_res, sin_v, cos_v;
  logic                mul_ovf, div_ovf;
  logic signed [63:0]  vclip;
  logic                vsat;

  // Constant and request-field operands.
  function automatic logic signed [63:0] konst(input oekf_pkg::src_e s,
                                               input oekf_pkg::job_t j,
                                               input oekf_pkg::cfg_t c);
    logic signed [63:0] v;
    begin
      unique case (s)
        oekf_pkg::K_ONE:       v = 64'sd1;
        oekf_pkg::K_ONE_Q16:   v = 64'sd65536;
        oekf_pkg::K_TWO_PI:    v = 64'sd411776;
        oekf_pkg::K_RADIUS:    v = $signed({32'd0, c.radius});
        oekf_pkg::K_TICKS:     v = $signed({48'd0, c.ticks});
        oekf_pkg::K_BASE:      v = $signed({32'd0, c.base});
        oekf_pkg::K_TRAVEL:    v = 64'(j.travel);
        oekf_pkg::K_TNOW:      v = $signed({32'd0, j.tnow});
        oekf_pkg::K_TBEF:      v = $signed({32'd0, j.tbef});
        oekf_pkg::K_ONE_SHL32: v = 64'sh1_0000_0000;
        oekf_pkg::K_STEER:     v = 64'(j.steer);
        oekf_pkg::K_HNOW:      v = 64'(j.hnow);
        oekf_pkg::K_HBEF:      v = 64'(j.hbef);
        default:               v = 64'sd0;
      endcase
      return v;
    end
  endfunction

  assign uop = oekf_pkg::prog_uop(job_q.prog, pc_q);

  // Operand selection: scratch entries carry their own overflow flag.
  always_comb begin
    if (uop.a[4]) begin
      va = konst(uop.a, job_q, cfg_i);
      fa = 1'b0;
    end else begin
      va = $signed(rda_q[63:0]);
      fa = rda_q[64];
    end
    if (uop.b[4]) begin
      vb = konst(uop.b, job_q, cfg_i);
      fb = 1'b0;
    end else begin
      vb = $signed(rdb_q[63:0]);
      fb = rdb_q[64];
    end
    vdiff = va - vb;
  end

  // Clip an emitted element to the output width.
  always_comb begin
    priority if (va > Lim) begin
      vclip = Lim;
      vsat  = 1'b1;
    end else if (va < -Lim - 64'sd1) begin
      vclip = -Lim - 64'sd1;
      vsat  = 1'b1;
    end else begin
      vclip = va;
      vsat  = 1'b0;
    end
  end

  // Sequencer: issue reads, start a unit or emit, then write back.
  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    oflag_d     = oflag_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    we          = 1'b0;
    waddr       = uop.dst[3:0];
    wdata       = '0;
    job_pop_o   = 1'b0;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    cor_start   = 1'b0;
    unique case (state_q)
      oekf_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          pc_d      = 5'd0;
          state_d   = oekf_pkg::BK_ISSUE;
        end
      end
      oekf_pkg::BK_ISSUE: begin
        state_d = oekf_pkg::BK_OPER;
      end
      oekf_pkg::BK_OPER: begin
        unique case (uop.kind)
          oekf_pkg::U_CORDIC: begin
            cor_start = 1'b1;
            oflag_d   = 1'b0;
            state_d   = oekf_pkg::BK_WAIT;
          end
          oekf_pkg::U_MUL: begin
            mul_start = 1'b1;
            oflag_d   = fa | fb;
            state_d   = oekf_pkg::BK_WAIT;
          end
          oekf_pkg::U_DIV: begin
            div_start = 1'b1;
            oflag_d   = fa | fb;
            state_d   = oekf_pkg::BK_WAIT;
          end
          oekf_pkg::U_SUB: begin
            we      = 1'b1;
            wdata   = {fa | fb, vdiff};
            pc_d    = pc_q + 5'd1;
            state_d = oekf_pkg::BK_ISSUE;
          end
          default: begin
            // Emit when the output register is free or being drained.
            if (!out_valid_q || !out_stall_i) begin
              out_valid_d     = 1'b1;
              out_d.row       = uop.row;
              out_d.col       = uop.col;
              out_d.value     = vclip[oekf_pkg::ValueW-1:0];
              out_d.saturated = fa | vsat;
              out_d.last      = uop.last;
              pc_d            = pc_q + 5'd1;
              state_d         = uop.last ? oekf_pkg::BK_IDLE : oekf_pkg::BK_ISSUE;
            end
          end
        endcase
      end
      oekf_pkg::BK_WAIT: begin
        priority if (mul_done) begin
          we      = 1'b1;
          wdata   = {oflag_q | mul_ovf, mul_res};
          pc_d    = pc_q + 5'd1;
          state_d = oekf_pkg::BK_ISSUE;
        end else if (div_done) begin
          we      = 1'b1;
          wdata   = {oflag_q | div_ovf, div_res};
          pc_d    = pc_q + 5'd1;
          state_d = oekf_pkg::BK_ISSUE;
        end else if (cor_done) begin
          we      = 1'b1;
          wdata   = {1'b0, sin_v};
          state_d = oekf_pkg::BK_COS;
        end else begin
          state_d = oekf_pkg::BK_WAIT;
        end
      end
      default: begin
        // Cosine goes to the entry after the sine.
        we      = 1'b1;
        waddr   = uop.dst[3:0] + 4'd1;
        wdata   = {1'b0, cos_v};
        pc_d    = pc_q + 5'd1;
        state_d = oekf_pkg::BK_ISSUE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oekf_pkg::BK_IDLE;
      pc_q        <= 5'd0;
      oflag_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      oflag_q     <= oflag_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: request held for the program, output element.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    out_q <= out_d;
  end

  // Scratch memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (state_q == oekf_pkg::BK_ISSUE) begin
      rda_q <= mem[uop.a[3:0]];
      rdb_q <= mem[uop.b[3:0]];
    end
  end

  oekf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (va),
    .b_i     (vb),
    .sh_i    (uop.sh),
    .done_o  (mul_done),
    .res_o   (mul_res),
    .ovf_o   (mul_ovf)
  );

  oekf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (va),
    .d_i     (vb),
    .done_o  (div_done),
    .res_o   (div_res),
    .ovf_o   (div_ovf)
  );

  oekf_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (va[15:0]),
    .done_o  (cor_done),
    .sin_o   (sin_v),
    .cos_o   (cos_v)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[rtl/odometry_ekf_jacobian_eval.sv]
// Jacobian evaluator for a steered-wheel odometry EKF. Each request yields
// the state Jacobian A (9 elements), the input Jacobian B (6) or the
// measurement row H (3), row-major, one element per output transaction;
// operation code 3 is accepted and yields nothing. Requests enter a
// two-deep queue at one per cycle while it is not full. The back end runs a
// separate micro-program for a steered and an unsteered A or B and one for H,
// sharing one 64-step divider (which saturates without iterating on a zero
// divisor), one 17-step CORDIC run once per angle, and one multiplier.
// Configuration writes are always ready and go straight into the registers.
// Depends on oekf_pkg, oekf_front and oekf_back.
module odometry_ekf_jacobian_eval (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  oekf_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output oekf_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  oekf_pkg::cfg_t cfg_q;
  logic           job_valid;
  oekf_pkg::job_t job;
  logic           job_pop;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks  <= 16'd1024;
      cfg_q.radius <= 32'd3277;
      cfg_q.base   <= 32'd16384;
    end else if (cfg_valid_i) begin
      unique case (oekf_pkg::cfg_idx_e'(cfg_index_i))
        oekf_pkg::CFG_TICKS:  cfg_q.ticks  <= cfg_data_i[15:0];
        oekf_pkg::CFG_RADIUS: cfg_q.radius <= cfg_data_i;
        oekf_pkg::CFG_BASE:   cfg_q.base   <= cfg_data_i;
        default:              cfg_q        <= cfg_q;
      endcase
    end
  end

  oekf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  oekf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
